### src/hcb_pkg.sv
// Shared types and codes for the Huffman code table builder.
package hcb_pkg;

   // Request opcodes.
   localparam logic [1:0] OP_COUNT = 2'd0;
   localparam logic [1:0] OP_BUILD = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Response status codes.
   localparam logic [1:0] ST_COUNTED = 2'd0;
   localparam logic [1:0] ST_BUILT   = 2'd1;
   localparam logic [1:0] ST_ENTRY   = 2'd2;
   localparam logic [1:0] ST_ERROR   = 2'd3;

   // Operation applied to every cell of the sorted node chain.
   typedef enum logic [1:0] {
      CH_HOLD,
      CH_INSERT,
      CH_POP2,
      CH_CLEAR
   } chain_op_type;

   typedef struct packed {
      chain_op_type op;
      logic         after_equal;
   } chain_ctrl_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_CNT_WR,
      S_LOAD_RD,
      S_LOAD_INS,
      S_MERGE,
      S_MERGE_INS,
      S_WALK_POP,
      S_WALK_GOT,
      S_WALK_KID,
      S_WALK_PUSH,
      S_READ,
      S_EMIT
   } state_type;

endpackage

### src/hcb_channels.sv
// Request and response channel interfaces of the Huffman code table builder.
interface hcb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] symbol;
   logic [7:0] entry_index;

   modport source (output valid, output opcode, output symbol, output entry_index,
                   input ready);
   modport sink (input valid, input opcode, input symbol, input entry_index,
                 output ready);
endinterface

interface hcb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  entry_symbol;
   logic [21:0] code_bits;
   logic [4:0]  code_length;
   logic [8:0]  entry_count;

   modport source (output valid, output status, output entry_symbol, output code_bits,
                   output code_length, output entry_count, input ready);
   modport sink (input valid, input status, input entry_symbol, input code_bits,
                 input code_length, input entry_count, output ready);
endinterface

### src/hcb_cell.sv
// One cell of the sorted node chain: holds a weight and a node id.
module hcb_cell #(
   parameter int WW = 16,
   parameter int NW = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hcb_pkg::chain_ctrl_type ctrl,
   input  logic [WW-1:0]          key_w,
   input  logic [NW-1:0]          key_id,
   input  logic                   prev_valid,
   input  logic [WW-1:0]          prev_w,
   input  logic [NW-1:0]          prev_id,
   input  logic                   prev_gt,
   input  logic                   skip_valid,
   input  logic [WW-1:0]          skip_w,
   input  logic [NW-1:0]          skip_id,
   output logic                   cell_valid,
   output logic [WW-1:0]          cell_w,
   output logic [NW-1:0]          cell_id,
   output logic                   gt
);

   logic          valid_ff, valid_in;
   logic [WW-1:0] w_ff, w_in;
   logic [NW-1:0] id_ff, id_in;

   // An empty cell ranks above any key; leaves go after equal weights,
   // parents before them.
   assign gt = !valid_ff || (ctrl.after_equal ? (w_ff > key_w) : (w_ff >= key_w));

   // Next contents: keep, take the key, take the left neighbor, shift by two, or clear.
   always_comb begin
      valid_in = valid_ff;
      w_in     = w_ff;
      id_in    = id_ff;
      case (ctrl.op)
         hcb_pkg::CH_INSERT: begin
            if (gt) begin
               if (prev_gt) begin
                  valid_in = prev_valid;
                  w_in     = prev_w;
                  id_in    = prev_id;
               end else begin
                  valid_in = 1'b1;
                  w_in     = key_w;
                  id_in    = key_id;
               end
            end
         end
         hcb_pkg::CH_POP2: begin
            valid_in = skip_valid;
            w_in     = skip_w;
            id_in    = skip_id;
         end
         hcb_pkg::CH_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      w_ff  <= w_in;
      id_ff <= id_in;
   end

   assign cell_valid = valid_ff;
   assign cell_w     = w_ff;
   assign cell_id    = id_ff;

endmodule

### src/hcb_chain.sv
// Row of cells keeping the live tree nodes sorted by weight.
module hcb_chain #(
   parameter int CELLS = 256,
   parameter int WW    = 16,
   parameter int NW    = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hcb_pkg::chain_ctrl_type ctrl,
   input  logic [WW-1:0]          key_w,
   input  logic [NW-1:0]          key_id,
   output logic                   h0_valid,
   output logic [WW-1:0]          h0_w,
   output logic [NW-1:0]          h0_id,
   output logic [WW-1:0]          h1_w,
   output logic [NW-1:0]          h1_id
);

   logic [CELLS-1:0] v;
   logic [CELLS-1:0] g;
   logic [WW-1:0]    w [CELLS];
   logic [NW-1:0]    id [CELLS];

   // Each cell sees its left neighbor for inserts and the cell two
   // to its right for the double pop.
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      logic          pv, pg, sv;
      logic [WW-1:0] pw, sw;
      logic [NW-1:0] pid, sid;

      if (i == 0) begin : g_first
         assign pv  = 1'b0;
         assign pw  = '0;
         assign pid = '0;
         assign pg  = 1'b0;
      end else begin : g_rest
         assign pv  = v[i-1];
         assign pw  = w[i-1];
         assign pid = id[i-1];
         assign pg  = g[i-1];
      end

      if (i + 2 < CELLS) begin : g_skip
         assign sv  = v[i+2];
         assign sw  = w[i+2];
         assign sid = id[i+2];
      end else begin : g_tail
         assign sv  = 1'b0;
         assign sw  = '0;
         assign sid = '0;
      end

      hcb_cell #(.WW(WW), .NW(NW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .key_w      (key_w),
         .key_id     (key_id),
         .prev_valid (pv),
         .prev_w     (pw),
         .prev_id    (pid),
         .prev_gt    (pg),
         .skip_valid (sv),
         .skip_w     (sw),
         .skip_id    (sid),
         .cell_valid (v[i]),
         .cell_w     (w[i]),
         .cell_id    (id[i]),
         .gt         (g[i])
      );
   end

   assign h0_valid = v[0];
   assign h0_w     = w[0];
   assign h0_id    = id[0];
   assign h1_w     = w[1];
   assign h1_id    = id[1];

endmodule

### src/huffman_code_table_builder.sv
// Top level of the Huffman code table builder: sequencer, stores and response register.
//
// Count and read transactions pass through one working state (S_CNT_WR or S_READ) and
// then S_EMIT, which loads the response register once it is free; a request rejected at
// acceptance goes straight to S_EMIT. A build transaction runs from the histogram: a
// scan loads the leaves into a sorted chain of cells (a store read for each symbol, then
// an insert for each counted one), each of the n-1 merges is a double pop, then an insert,
// and the preorder walk over the 2n-1 tree nodes pops each node from the stack, writes a
// leaf to the table and has an inner node fetch its children and push both. One
// transaction is processed at a time; a new one is accepted while the previous response
// still waits in the output register.
module huffman_code_table_builder #(
   parameter int ALPHABET_SIZE = 256,
   parameter int COUNT_WIDTH   = 16,
   parameter int MAX_CODE_LEN  = 22
) (
   input  logic      clock,
   input  logic      reset,
   hcb_req_if.sink   req_ch,
   hcb_rsp_if.source rsp_ch
);

   localparam int AW = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int EW = $clog2(ALPHABET_SIZE + 1);
   localparam int NW = $clog2(2 * ALPHABET_SIZE);
   localparam int CW = COUNT_WIDTH;
   localparam int CL = MAX_CODE_LEN;
   localparam int LW = $clog2(MAX_CODE_LEN + 1);
   localparam int SW = NW + CL + LW;

   // Sequencer and bookkeeping registers.
   hcb_pkg::state_type state_ff, state_in;
   logic          built_ff, built_in;
   logic [CW-1:0] total_ff, total_in;
   logic [EW-1:0] te_ff, te_in;
   logic [EW-1:0] n_ff, n_in;
   logic [EW-1:0] s_ff, s_in;
   logic [EW-1:0] sp_ff, sp_in;
   logic [NW-1:0] nxt_ff, nxt_in;
   logic [AW-1:0] sym_ff, sym_in;
   logic [CW-1:0] key_w_ff, key_w_in;
   logic [NW-1:0] key_id_ff, key_id_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [NW-1:0] res_sym_ff, res_sym_in;
   logic [CL-1:0] res_code_ff, res_code_in;
   logic [LW-1:0] res_len_ff, res_len_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_sym_ff, rsp_sym_in;
   logic [21:0] rsp_code_ff, rsp_code_in;
   logic [4:0]  rsp_len_ff, rsp_len_in;
   logic [8:0]  rsp_count_ff, rsp_count_in;

   // Stores.
   logic [CW-1:0]          cnt_mem [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] cnt_valid_ff;
   logic [CW-1:0]          cnt_rd_ff;
   logic                   cnt_vld_rd_ff;
   logic                   cnt_re, cnt_we, cnt_clr;
   logic [AW-1:0]          cnt_raddr, cnt_waddr;
   logic [CW-1:0]          cnt_wdata;

   logic [2*NW-1:0] kid_mem [ALPHABET_SIZE];
   logic [2*NW-1:0] kid_rd_ff;
   logic            kid_re, kid_we;
   logic [AW-1:0]   kid_raddr, kid_waddr;
   logic [2*NW-1:0] kid_wdata;

   logic [SW-1:0] stk_mem [ALPHABET_SIZE];
   logic [SW-1:0] stk_rd_ff;
   logic          stk_re, stk_we;
   logic [AW-1:0] stk_raddr, stk_waddr;
   logic [SW-1:0] stk_wdata;

   logic [SW-1:0] tbl_mem [ALPHABET_SIZE];
   logic [SW-1:0] tbl_rd_ff;
   logic          tbl_re, tbl_we;
   logic [AW-1:0] tbl_raddr, tbl_waddr;
   logic [SW-1:0] tbl_wdata;

   // Chain interface.
   hcb_pkg::chain_ctrl_type ch_ctrl;
   logic [CW-1:0] ch_key_w;
   logic [NW-1:0] ch_key_id;
   logic          h0_valid;
   logic [CW-1:0] h0_w, h1_w;
   logic [NW-1:0] h0_id, h1_id;

   // Fields of the stack entry being walked.
   logic [NW-1:0] wk_node;
   logic [CL-1:0] wk_code;
   logic [LW-1:0] wk_len;

   assign wk_node = stk_rd_ff[SW-1 -: NW];
   assign wk_code = stk_rd_ff[LW +: CL];
   assign wk_len  = stk_rd_ff[LW-1:0];

   hcb_chain #(.CELLS(ALPHABET_SIZE), .WW(CW), .NW(NW)) u_chain (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ch_ctrl),
      .key_w    (ch_key_w),
      .key_id   (ch_key_id),
      .h0_valid (h0_valid),
      .h0_w     (h0_w),
      .h0_id    (h0_id),
      .h1_w     (h1_w),
      .h1_id    (h1_id)
   );

   // Next state and store controls.
   always_comb begin
      state_in      = state_ff;
      built_in      = built_ff;
      total_in      = total_ff;
      te_in         = te_ff;
      n_in          = n_ff;
      s_in          = s_ff;
      sp_in         = sp_ff;
      nxt_in        = nxt_ff;
      sym_in        = sym_ff;
      key_w_in      = key_w_ff;
      key_id_in     = key_id_ff;
      res_status_in = res_status_ff;
      res_sym_in    = res_sym_ff;
      res_code_in   = res_code_ff;
      res_len_in    = res_len_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_count_in  = rsp_count_ff;

      ch_ctrl.op          = hcb_pkg::CH_HOLD;
      ch_ctrl.after_equal = 1'b0;
      ch_key_w            = key_w_ff;
      ch_key_id           = key_id_ff;

      req_ch.ready = 1'b0;
      cnt_re    = 1'b0;
      cnt_we    = 1'b0;
      cnt_clr   = 1'b0;
      cnt_raddr = AW'(req_ch.symbol);
      cnt_waddr = sym_ff;
      cnt_wdata = (cnt_vld_rd_ff ? cnt_rd_ff : '0) + CW'(1);
      kid_re    = 1'b0;
      kid_we    = 1'b0;
      kid_raddr = AW'(wk_node - NW'(ALPHABET_SIZE));
      kid_waddr = AW'(nxt_ff - NW'(ALPHABET_SIZE));
      kid_wdata = {h1_id, h0_id};
      stk_re    = 1'b0;
      stk_we    = 1'b0;
      stk_raddr = AW'(sp_ff - EW'(1));
      stk_waddr = AW'(sp_ff);
      stk_wdata = {kid_rd_ff[NW-1:0], wk_code, wk_len + LW'(1)};
      tbl_re    = 1'b0;
      tbl_we    = 1'b0;
      tbl_raddr = AW'(req_ch.entry_index);
      tbl_waddr = AW'(te_ff);
      tbl_wdata = stk_rd_ff;

      case (state_ff)
         hcb_pkg::S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               res_status_in = hcb_pkg::ST_ERROR;
               res_sym_in    = '0;
               res_code_in   = '0;
               res_len_in    = '0;
               state_in      = hcb_pkg::S_EMIT;
               case (req_ch.opcode)
                  hcb_pkg::OP_COUNT: begin
                     if ({1'b0, req_ch.symbol} < 9'(ALPHABET_SIZE)) begin
                        // A count after a build starts a new message.
                        if (built_ff) begin
                           cnt_clr  = 1'b1;
                           total_in = '0;
                           te_in    = '0;
                           built_in = 1'b0;
                        end
                        if (built_ff || total_ff != {CW{1'b1}}) begin
                           cnt_re   = 1'b1;
                           sym_in   = AW'(req_ch.symbol);
                           state_in = hcb_pkg::S_CNT_WR;
                        end
                     end
                  end
                  hcb_pkg::OP_BUILD: begin
                     if (total_ff == '0) begin
                        built_in = 1'b0;
                        te_in    = '0;
                     end else begin
                        ch_ctrl.op = hcb_pkg::CH_CLEAR;
                        s_in       = '0;
                        n_in       = '0;
                        nxt_in     = NW'(ALPHABET_SIZE);
                        state_in   = hcb_pkg::S_LOAD_RD;
                     end
                  end
                  hcb_pkg::OP_READ: begin
                     if (built_ff && {1'b0, req_ch.entry_index} < 9'(te_ff) &&
                         {1'b0, req_ch.entry_index} < 9'(ALPHABET_SIZE)) begin
                        tbl_re   = 1'b1;
                        state_in = hcb_pkg::S_READ;
                     end
                  end
                  default: begin
                     state_in = hcb_pkg::S_EMIT;
                  end
               endcase
            end
         end

         hcb_pkg::S_CNT_WR: begin
            cnt_we        = 1'b1;
            total_in      = total_ff + CW'(1);
            res_status_in = hcb_pkg::ST_COUNTED;
            state_in      = hcb_pkg::S_EMIT;
         end

         // Scan the histogram in symbol order.
         hcb_pkg::S_LOAD_RD: begin
            if (s_ff == EW'(ALPHABET_SIZE)) begin
               state_in = hcb_pkg::S_MERGE;
            end else begin
               cnt_re    = 1'b1;
               cnt_raddr = AW'(s_ff);
               key_id_in = NW'(s_ff);
               s_in      = s_ff + EW'(1);
               state_in  = hcb_pkg::S_LOAD_INS;
            end
         end

         hcb_pkg::S_LOAD_INS: begin
            if (cnt_vld_rd_ff) begin
               ch_ctrl.op          = hcb_pkg::CH_INSERT;
               ch_ctrl.after_equal = 1'b1;
               ch_key_w            = cnt_rd_ff;
               n_in                = n_ff + EW'(1);
            end
            state_in = hcb_pkg::S_LOAD_RD;
         end

         // Merge the two lightest nodes, or start the walk at the root.
         hcb_pkg::S_MERGE: begin
            if (n_ff == EW'(1)) begin
               stk_we    = 1'b1;
               stk_waddr = '0;
               stk_wdata = {h0_id, {CL{1'b0}}, {LW{1'b0}}};
               sp_in     = EW'(1);
               te_in     = '0;
               state_in  = hcb_pkg::S_WALK_POP;
            end else begin
               kid_we     = 1'b1;
               key_w_in   = h0_w + h1_w;
               key_id_in  = nxt_ff;
               ch_ctrl.op = hcb_pkg::CH_POP2;
               n_in       = n_ff - EW'(2);
               nxt_in     = nxt_ff + NW'(1);
               state_in   = hcb_pkg::S_MERGE_INS;
            end
         end

         hcb_pkg::S_MERGE_INS: begin
            ch_ctrl.op = hcb_pkg::CH_INSERT;
            n_in       = n_ff + EW'(1);
            state_in   = hcb_pkg::S_MERGE;
         end

         hcb_pkg::S_WALK_POP: begin
            if (sp_ff == '0) begin
               built_in      = 1'b1;
               res_status_in = hcb_pkg::ST_BUILT;
               state_in      = hcb_pkg::S_EMIT;
            end else begin
               stk_re   = 1'b1;
               sp_in    = sp_ff - EW'(1);
               state_in = hcb_pkg::S_WALK_GOT;
            end
         end

         // Leaf: table entry. Inner node: fetch children, or error at max code length.
         hcb_pkg::S_WALK_GOT: begin
            if (wk_node < NW'(ALPHABET_SIZE)) begin
               tbl_we   = 1'b1;
               te_in    = te_ff + EW'(1);
               state_in = hcb_pkg::S_WALK_POP;
            end else if (wk_len >= LW'(MAX_CODE_LEN)) begin
               built_in      = 1'b0;
               te_in         = '0;
               res_status_in = hcb_pkg::ST_ERROR;
               state_in      = hcb_pkg::S_EMIT;
            end else begin
               kid_re   = 1'b1;
               state_in = hcb_pkg::S_WALK_KID;
            end
         end

         // Push the right child (bit 0) first, then the left child (bit 1).
         hcb_pkg::S_WALK_KID: begin
            stk_we   = 1'b1;
            state_in = hcb_pkg::S_WALK_PUSH;
         end

         hcb_pkg::S_WALK_PUSH: begin
            stk_we    = 1'b1;
            stk_waddr = AW'(sp_ff + EW'(1));
            stk_wdata = {kid_rd_ff[2*NW-1:NW], wk_code | (CL'(1) << wk_len),
                         wk_len + LW'(1)};
            sp_in     = sp_ff + EW'(2);
            state_in  = hcb_pkg::S_WALK_POP;
         end

         hcb_pkg::S_READ: begin
            res_status_in = hcb_pkg::ST_ENTRY;
            res_sym_in    = tbl_rd_ff[SW-1 -: NW];
            res_code_in   = tbl_rd_ff[LW +: CL];
            res_len_in    = tbl_rd_ff[LW-1:0];
            state_in      = hcb_pkg::S_EMIT;
         end

         // Hand the result to the response register once it is free.
         hcb_pkg::S_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_sym_in    = 8'(res_sym_ff);
               rsp_code_in   = 22'(res_code_ff);
               rsp_len_in    = 5'(res_len_ff);
               rsp_count_in  = built_ff ? 9'(te_ff) : '0;
               state_in      = hcb_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = hcb_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hcb_pkg::S_IDLE;
         built_ff     <= 1'b0;
         total_ff     <= '0;
         te_ff        <= '0;
         n_ff         <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         built_ff     <= built_in;
         total_ff     <= total_in;
         te_ff        <= te_in;
         n_ff         <= n_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s_ff          <= s_in;
      nxt_ff        <= nxt_in;
      sym_ff        <= sym_in;
      key_w_ff      <= key_w_in;
      key_id_ff     <= key_id_in;
      res_status_ff <= res_status_in;
      res_sym_ff    <= res_sym_in;
      res_code_ff   <= res_code_in;
      res_len_ff    <= res_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // Histogram valid bits: an entry without its bit reads as zero.
   always_ff @(posedge clock) begin
      if (reset || cnt_clr) begin
         cnt_valid_ff <= '0;
      end else if (cnt_we) begin
         cnt_valid_ff[cnt_waddr] <= 1'b1;
      end
   end

   // Histogram store.
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cnt_re) begin
         cnt_rd_ff     <= cnt_mem[cnt_raddr];
         cnt_vld_rd_ff <= cnt_valid_ff[cnt_raddr] && !cnt_clr;
      end
   end

   // Child store of the inner nodes.
   always_ff @(posedge clock) begin
      if (kid_we) begin
         kid_mem[kid_waddr] <= kid_wdata;
      end
      if (kid_re) begin
         kid_rd_ff <= kid_mem[kid_raddr];
      end
   end

   // Walk stack.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

   // Code table.
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_raddr];
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.entry_symbol = rsp_sym_ff;
   assign rsp_ch.code_bits    = rsp_code_ff;
   assign rsp_ch.code_length  = rsp_len_ff;
   assign rsp_ch.entry_count  = rsp_count_ff;

`ifndef SYNTHESIS
   // A merge always finds at least one node at the head of the chain.
   a_merge_head: assert property (@(posedge clock) disable iff (reset)
      state_ff == hcb_pkg::S_MERGE |-> h0_valid)
      else $error("merge step with an empty node chain");

   // An entry is only returned from a table that has entries.
   a_entry_count: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == hcb_pkg::ST_ENTRY |-> rsp_ch.entry_count != 9'd0)
      else $error("entry returned with an empty table");

   // The walk stack never grows past its store.
   a_stack_depth: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= EW'(ALPHABET_SIZE))
      else $error("walk stack overflow");
`endif

endmodule
